// ===== design/sfp_pkg.sv =====
// Shared constants, types and the layout scoring function for the sensor frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

  localparam int unsigned BufDepth  = 64;
  localparam int unsigned PosWidth  = $clog2(BufDepth + 1);
  localparam int unsigned LenWidth  = 9;

  localparam logic [7:0] StartByte = 8'h16;
  localparam logic [7:0] MinLen    = 8'h0B;
  localparam logic [7:0] CmdRead   = 8'h01;
  localparam logic [7:0] CmdAlt    = 8'h02;

  // Bytes 3..13 of a frame hold every field of every layout.
  localparam int unsigned FieldFirst = 3;
  localparam int unsigned FieldLast  = 13;
  localparam int unsigned NumFieldB  = FieldLast - FieldFirst + 1;
  localparam int unsigned NumLayouts = 4;

  localparam logic [16:0] TempOffset = 17'd500;

  localparam int unsigned DataBits = 16 * 4 + 17;
  localparam int unsigned TdataOut = ((DataBits + 7) / 8) * 8;

  typedef logic [4:0] score_t;

  typedef struct packed {
    logic [15:0] pm25_level;
    logic [16:0] temperature_tenths;
    logic [15:0] humidity_tenths;
    logic [15:0] voc_level;
    logic [15:0] co2_ppm;
  } sfp_result_t;

  function automatic score_t layout_score(input logic [15:0] co2, input logic [15:0] voc,
                                          input logic [15:0] h, input logic [15:0] t,
                                          input logic [15:0] pm);
    score_t s;
    s = '0;
    if (co2 <= 16'd5000) s = s + score_t'(3);
    if (co2 >= 16'd250 && co2 <= 16'd2500) s = s + score_t'(2);
    if (h <= 16'd1000) s = s + score_t'(3);
    if (h >= 16'd200 && h <= 16'd900) s = s + score_t'(1);
    if (t >= 16'd300 && t <= 16'd1300) s = s + score_t'(3);
    if (t >= 16'd600 && t <= 16'd950) s = s + score_t'(1);
    if (pm <= 16'd2000) s = s + score_t'(2);
    if (pm <= 16'd500) s = s + score_t'(1);
    if (voc <= 16'd5000) s = s + score_t'(1);
    return s;
  endfunction

endpackage

// ===== design/sfp_layout_pick.sv =====
// Decodes the four field layouts of a checked frame, scores them and picks the best one.
`timescale 1ns / 1ps

module sfp_layout_pick import sfp_pkg::*; (
  input  logic [NumFieldB-1:0][7:0] field_bytes_i,
  input  logic                      wide_ok_i,
  output sfp_result_t               result_o
);

  logic [NumLayouts-1:0][4:0][15:0] vals;
  score_t [NumLayouts-1:0]          scores;
  logic [NumLayouts-1:0]            usable;

  always_comb begin
    for (int k = 0; k < NumLayouts; k++) begin
      for (int j = 0; j < 5; j++) begin
        if (k >= 2) begin
          vals[k][j] = {field_bytes_i[(k % 2) + 2 * j + 1], field_bytes_i[(k % 2) + 2 * j]};
        end else begin
          vals[k][j] = {field_bytes_i[(k % 2) + 2 * j], field_bytes_i[(k % 2) + 2 * j + 1]};
        end
      end
      scores[k] = layout_score(vals[k][0], vals[k][1], vals[k][2], vals[k][3], vals[k][4]);
      usable[k] = (k % 2 == 0) ? 1'b1 : wide_ok_i;
    end
  end

  logic [1:0] best_idx;
  score_t     best_score;

  always_comb begin
    best_idx   = 2'd0;
    best_score = scores[0];
    for (int k = 1; k < NumLayouts; k++) begin
      if (usable[k] && scores[k] > best_score) begin
        best_idx   = 2'(k);
        best_score = scores[k];
      end
    end
  end

  always_comb begin
    result_o.co2_ppm            = vals[best_idx][0];
    result_o.voc_level          = vals[best_idx][1];
    result_o.humidity_tenths    = vals[best_idx][2];
    result_o.temperature_tenths = {1'b0, vals[best_idx][3]} - TempOffset;
    result_o.pm25_level         = vals[best_idx][4];
  end

endmodule

// ===== design/sensor_frame_parser_scored_layout.sv =====
// Top level of the sensor frame parser: byte framing, checksum, layout scoring and output.
`timescale 1ns / 1ps

// Takes one received byte per cycle on the slave stream and hunts for the 0x16 start byte,
// then the length byte L; a frame is L+3 bytes, at most 64. The checksum runs as bytes
// arrive and payload bytes 3..13 are captured in registers, so the frame check finishes
// with its last byte. The layout scoring and selection then run in one stage, and the
// result is registered into out_q, with out_valid_q set, once fin_q flags the checked frame.
// Input throughput is one byte per cycle; tready drops only while a finished frame waits
// behind a result that the sink has not yet taken.

module sensor_frame_parser_scored_layout import sfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  input  logic [7:0]          s_axis_tdata_i,  // rx_byte
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // co2_ppm, voc_level, humidity_tenths, temperature_tenths, pm25_level, zero fill
  output logic [TdataOut-1:0] m_axis_tdata_o
);

  logic [PosWidth-1:0] pos_q, pos_d;
  logic [7:0]          sum_q, sum_d;
  logic [7:0]          len_q, len_d;
  logic [7:0]          cmd_q, cmd_d;
  logic [NumFieldB-1:0][7:0] fb_q, fb_d;
  logic                fin_q, fin_d;
  logic                out_valid_q, out_valid_d;
  sfp_result_t         out_q;
  sfp_result_t         pick;

  logic                in_xfer;
  logic                out_load;
  logic [7:0]          b;
  logic [7:0]          len_sel;
  logic [7:0]          cmd_sel;
  logic [LenWidth-1:0] expected;
  logic [PosWidth-1:0] pos_inc;
  logic                frame_ok;
  logic                finish;

  assign b        = s_axis_tdata_i;
  assign in_xfer  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load = fin_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !(fin_q && out_valid_q && !m_axis_tready_i);

  assign len_sel  = (pos_q == PosWidth'(1)) ? b : len_q;
  assign cmd_sel  = (pos_q == PosWidth'(2)) ? b : cmd_q;
  assign expected = LenWidth'(len_sel) + LenWidth'(3);
  assign pos_inc  = pos_q + PosWidth'(1);
  assign frame_ok = (sum_q + b == 8'h00) && (cmd_sel == CmdRead || cmd_sel == CmdAlt) &&
                    (len_sel >= MinLen);

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    len_d  = len_q;
    cmd_d  = cmd_q;
    fb_d   = fb_q;
    finish = 1'b0;
    if (in_xfer) begin
      if (pos_q == '0) begin
        if (b == StartByte) begin
          pos_d = PosWidth'(1);
          sum_d = b;
        end
      end else begin
        sum_d = sum_q + b;
        if (pos_q == PosWidth'(1)) len_d = b;
        if (pos_q == PosWidth'(2)) cmd_d = b;
        for (int i = 0; i < NumFieldB; i++) begin
          if (pos_q == PosWidth'(FieldFirst + i)) fb_d[i] = b;
        end
        if (expected > LenWidth'(BufDepth)) begin
          pos_d = '0;
        end else if (LenWidth'(pos_inc) == expected) begin
          pos_d  = '0;
          finish = frame_ok;
        end else if (pos_inc >= PosWidth'(BufDepth)) begin
          pos_d = '0;
        end else begin
          pos_d = pos_inc;
        end
      end
    end
  end

  always_comb begin
    fin_d = fin_q;
    if (finish) begin
      fin_d = 1'b1;
    end else if (out_load) begin
      fin_d = 1'b0;
    end
    out_valid_d = out_load || (out_valid_q && !m_axis_tready_i);
  end

  sfp_layout_pick u_pick (
    .field_bytes_i (fb_q),
    .wide_ok_i     (len_q > MinLen),
    .result_o      (pick)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= '0;
      fin_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      fin_q       <= fin_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    len_q <= len_d;
    cmd_q <= cmd_d;
    fb_q  <= fb_d;
    if (out_load) out_q <= pick;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(TdataOut - DataBits){1'b0}}, out_q};

  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q < PosWidth'(BufDepth))
    else $error("frame position out of range");

  a_fin_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_q |-> pos_q == '0)
    else $error("finished frame pending while a new frame is under way");

  a_out_from_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(fin_q))
    else $error("result appeared without a checked frame");

endmodule

// ===== tb/sfp_reading_monitor.sv =====
// Stream monitor for the sensor frame parser: tracks frames, predicts readings and checks them.
`timescale 1ns / 1ps

module sfp_reading_monitor import sfp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                rx_valid_i,
  input  logic                rx_ready_i,
  input  logic [7:0]          rx_byte_i,
  input  logic                rd_valid_i,
  input  logic                rd_ready_i,
  input  logic [TdataOut-1:0] rd_data_i,
  output int unsigned         mismatches_o,
  output int unsigned         pending_o
);

  logic [7:0]  frame_bytes [BufDepth];
  int unsigned frame_fill = 0;
  int unsigned errors = 0;
  sfp_result_t readings_due [$];

  function automatic int plausibility(input logic [15:0] co2, voc, hum, temp, pm);
    int s;
    s = 0;
    if (co2 <= 16'd5000) s += 3;
    if (co2 >= 16'd250 && co2 <= 16'd2500) s += 2;
    if (hum <= 16'd1000) s += 3;
    if (hum >= 16'd200 && hum <= 16'd900) s += 1;
    if (temp >= 16'd300 && temp <= 16'd1300) s += 3;
    if (temp >= 16'd600 && temp <= 16'd950) s += 1;
    if (pm <= 16'd2000) s += 2;
    if (pm <= 16'd500) s += 1;
    if (voc <= 16'd5000) s += 1;
    return s;
  endfunction

  // Checksum, command and length checks, then best-scoring layout.
  function automatic bit judge_frame(input int unsigned total, output sfp_result_t r);
    logic [7:0]  sum;
    logic [7:0]  len;
    logic [15:0] v [5];
    logic [15:0] pick [5];
    int          best;
    int          s;
    int unsigned base;
    int unsigned i;
    int unsigned j;
    int unsigned k;
    r = '0;
    sum = '0;
    len = frame_bytes[1];
    for (i = 0; i < total; i++) sum += frame_bytes[i];
    if (sum != 8'h00) return 1'b0;
    if (frame_bytes[2] != CmdRead && frame_bytes[2] != CmdAlt) return 1'b0;
    if (len < MinLen) return 1'b0;
    best = -1;
    // order: off3 BE, off4 BE, off3 LE, off4 LE
    for (k = 0; k < NumLayouts; k++) begin
      base = (k % 2 == 1) ? 4 : 3;
      if (base + 8 > len) continue;
      for (j = 0; j < 5; j++) begin
        if (k >= 2) v[j] = {frame_bytes[base + 2 * j + 1], frame_bytes[base + 2 * j]};
        else v[j] = {frame_bytes[base + 2 * j], frame_bytes[base + 2 * j + 1]};
      end
      s = plausibility(v[0], v[1], v[2], v[3], v[4]);
      if (s > best) begin
        best = s;
        pick = v;
      end
    end
    r.co2_ppm            = pick[0];
    r.voc_level          = pick[1];
    r.humidity_tenths    = pick[2];
    r.temperature_tenths = {1'b0, pick[3]} - TempOffset;
    r.pm25_level         = pick[4];
    return 1'b1;
  endfunction

  function automatic bit absorb_byte(input logic [7:0] b, output sfp_result_t r);
    int unsigned total;
    bit          hit;
    hit = 1'b0;
    r = '0;
    if (frame_fill >= BufDepth) frame_fill = 0;
    if (frame_fill == 0) begin
      if (b == StartByte) begin
        frame_bytes[0] = b;
        frame_fill = 1;
      end
      return 1'b0;
    end
    frame_bytes[frame_fill] = b;
    frame_fill++;
    total = int'(frame_bytes[1]) + 3;
    if (total > BufDepth) begin
      frame_fill = 0;
      return 1'b0;
    end
    if (frame_fill == total) begin
      hit = judge_frame(total, r);
      frame_fill = 0;
    end
    if (frame_fill >= BufDepth) frame_fill = 0;
    return hit;
  endfunction

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    sfp_result_t fresh;
    sfp_result_t seen;
    sfp_result_t want;
    if (!rst_ni) begin
      frame_fill = 0;
      readings_due.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
    end else begin
      if (rx_valid_i && rx_ready_i) begin
        if (absorb_byte(rx_byte_i, fresh)) readings_due.push_back(fresh);
      end
      if (rd_valid_i && rd_ready_i) begin
        seen = rd_data_i[$bits(sfp_result_t)-1:0];
        if (readings_due.size() == 0) begin
          $error("reading transfer with none expected: %h", rd_data_i);
          errors++;
        end else begin
          want = readings_due.pop_front();
          check_field("co2_ppm", want.co2_ppm, seen.co2_ppm);
          check_field("voc_level", want.voc_level, seen.voc_level);
          check_field("humidity_tenths", want.humidity_tenths, seen.humidity_tenths);
          check_field("temperature_tenths", int'($signed(want.temperature_tenths)),
                      int'($signed(seen.temperature_tenths)));
          check_field("pm25_level", want.pm25_level, seen.pm25_level);
          check_field("zero_fill", 0, int'(rd_data_i[TdataOut-1:$bits(sfp_result_t)]));
        end
      end
      mismatches_o <= errors;
      pending_o    <= readings_due.size();
    end
  end

endmodule

// ===== tb/sensor_frame_parser_scored_layout_tb.sv =====
// Top of the sensor frame parser testbench: clock, reset, byte stimulus, sink stalls, verdict.
`timescale 1ns / 1ps

module sensor_frame_parser_scored_layout_tb;
  import sfp_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomBytes = 1100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [7:0]          s_axis_tdata_i = '0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [TdataOut-1:0] m_axis_tdata_o;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned bytes_sent = 0;
  logic [7:0]  frame_q [$];

  sensor_frame_parser_scored_layout u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  sfp_reading_monitor u_monitor (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rx_valid_i   (s_axis_tvalid_i),
    .rx_ready_i   (s_axis_tready_o),
    .rx_byte_i    (s_axis_tdata_i),
    .rd_valid_i   (m_axis_tvalid_o),
    .rd_ready_i   (m_axis_tready_i),
    .rd_data_i    (m_axis_tdata_o),
    .mismatches_o (mismatches),
    .pending_o    (pending)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= stall_pct);
  end

  initial begin
    repeat (CycleLimit) @(posedge clk_i);
    $display("[sensor_frame_parser_scored_layout] ERROR");
    $finish;
  end

  // slot order: co2, voc, humidity, temperature, pm25
  function automatic logic [15:0] field_value(input int unsigned slot);
    int unsigned marks [5][8] = '{
      '{249, 250, 2500, 2501, 5000, 5001, 0, 65535},
      '{0, 1, 4999, 5000, 5001, 5002, 100, 65535},
      '{199, 200, 900, 901, 1000, 1001, 0, 65535},
      '{299, 300, 599, 600, 950, 951, 1300, 1301},
      '{499, 500, 501, 1999, 2000, 2001, 0, 65535}
    };
    int unsigned lo [5] = '{250, 0, 200, 600, 0};
    int unsigned hi [5] = '{2500, 5000, 900, 950, 500};
    case ($urandom_range(0, 3))
      0: return 16'(marks[slot][$urandom_range(0, 7)]);
      1: return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(lo[slot], hi[slot]));
    endcase
  endfunction

  // fill < 0: random payload with edge, random or in-range fields under one random layout
  task automatic build_frame(input int unsigned len, input logic [7:0] cmd, input bit bad_sum,
                             input int fill);
    logic [7:0]  body [64];
    logic [7:0]  sum;
    logic [15:0] val;
    int unsigned total;
    int unsigned base;
    int unsigned idx;
    int unsigned j;
    bit          little;
    total = len + 3;
    body[0] = StartByte;
    body[1] = 8'(len);
    body[2] = cmd;
    for (idx = 3; idx < total; idx++) begin
      body[idx] = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
    end
    if (fill < 0) begin
      base = $urandom_range(3, 4);
      little = 1'($urandom_range(0, 1));
      for (j = 0; j < 5; j++) begin
        val = field_value(j);
        if (base + 2 * j + 1 < total - 1) begin
          body[base + 2 * j]     = little ? val[7:0] : val[15:8];
          body[base + 2 * j + 1] = little ? val[15:8] : val[7:0];
        end
      end
    end
    sum = '0;
    for (idx = 0; idx < total - 1; idx++) sum += body[idx];
    body[total - 1] = 8'h00 - sum;
    if (bad_sum) body[total - 1] += 8'($urandom_range(1, 255));
    for (idx = 0; idx < total; idx++) frame_q.push_back(body[idx]);
  endtask

  task automatic send_byte(input logic [7:0] value);
    if ($urandom_range(0, 99) < idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < idle_pct);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= value;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_queued();
    while (frame_q.size() != 0) send_byte(frame_q.pop_front());
  endtask

  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_random_case();
    int unsigned pick;
    int unsigned len;
    logic [7:0]  cmd;
    pick = $urandom_range(0, 99);
    cmd = $urandom_range(0, 1) ? CmdAlt : CmdRead;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 61) : $urandom_range(11, 16);
    if (pick < 70) begin
      build_frame(len, cmd, 1'b0, -1);
    end else if (pick < 78) begin
      build_frame(len, cmd, 1'b1, -1);
    end else if (pick < 84) begin
      do cmd = 8'($urandom_range(0, 255)); while (cmd == CmdRead || cmd == CmdAlt);
      build_frame(len, cmd, 1'b0, -1);
    end else if (pick < 90) begin
      build_frame($urandom_range(0, 10), cmd, 1'b0, -1);
    end else if (pick < 94) begin
      frame_q.push_back(StartByte);
      frame_q.push_back(8'($urandom_range(62, 255)));
      repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      if ($urandom_range(0, 1)) frame_q.push_back(StartByte);
      repeat ($urandom_range(1, 8)) frame_q.push_back(8'($urandom_range(0, 255)));
    end
    send_queued();
  endtask

  initial begin
    int unsigned phase;
    int unsigned first;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed frames
    build_frame(11, CmdRead, 1'b0, -1);
    build_frame(12, CmdAlt, 1'b0, -1);
    build_frame(61, CmdRead, 1'b0, -1);
    build_frame(11, CmdRead, 1'b0, 8'h00);
    build_frame(13, CmdAlt, 1'b0, 8'hFF);
    build_frame(12, CmdRead, 1'b1, -1);
    build_frame(12, 8'h00, 1'b0, -1);
    build_frame(12, 8'h03, 1'b0, -1);
    build_frame(14, 8'hFF, 1'b0, -1);
    build_frame(10, CmdRead, 1'b0, -1);
    build_frame(0, CmdRead, 1'b0, -1);
    frame_q.push_back(StartByte);
    frame_q.push_back(8'd62);
    build_frame(15, CmdAlt, 1'b0, -1);
    frame_q.push_back(StartByte);
    frame_q.push_back(8'hFF);
    frame_q.push_back(8'h00);
    frame_q.push_back(8'hFF);
    build_frame(20, CmdRead, 1'b0, -1);
    send_queued();
    wait_drained();

    first = bytes_sent;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 62;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 62;
        end
        default: begin
          idle_pct = 27;
          stall_pct = 27;
        end
      endcase
      while (bytes_sent - first < RandomBytes * (phase + 1) / 4) begin
        send_random_case();
      end
      wait_drained();
    end

    stall_pct = 0;
    repeat (16) @(posedge clk_i);
    if (mismatches == 0 && pending == 0) begin
      $display("[sensor_frame_parser_scored_layout] OK");
    end else begin
      if (pending != 0) $error("%0d expected readings never arrived", pending);
      $display("[sensor_frame_parser_scored_layout] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/sfp_pkg.sv
design/sfp_layout_pick.sv
design/sensor_frame_parser_scored_layout.sv
tb/sfp_reading_monitor.sv
tb/sensor_frame_parser_scored_layout_tb.sv
